>>> hw/rtl/mssn_pkg.sv
package mssn_pkg;

   localparam int DIGITS      = 4;
   localparam int NUMBER_W    = 14;
   localparam int SEG_W       = 7;
   localparam int DPLACE_W    = 2;
   localparam int PLACE_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // divide by ten: q = (x * 52429) >> 19, exact for x below 43699
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = NUMBER_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(52429);

   localparam logic [PLACE_W-1:0] LAST_PLACE = PLACE_W'(DIGITS - 1);

   localparam logic CMD_SHOW  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [SEG_W-1:0] SEG_BLANK = '0;

   typedef struct packed {
      logic                blank;
      logic [NUMBER_W-1:0] number;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 7'b0111111;
         4'd1:    seg = 7'b0000110;
         4'd2:    seg = 7'b1011011;
         4'd3:    seg = 7'b1001111;
         4'd4:    seg = 7'b1100110;
         4'd5:    seg = 7'b1101101;
         4'd6:    seg = 7'b1111101;
         4'd7:    seg = 7'b0000111;
         4'd8:    seg = 7'b1111111;
         4'd9:    seg = 7'b1101111;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

>>> hw/rtl/mssn_front.sv
module mssn_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic [mssn_pkg::NUMBER_W-1:0] req_number,
   input  mssn_pkg::queue_status_type   qstat,
   output logic                         push,
   output mssn_pkg::item_type           push_item
);

   logic               stage_valid_ff, stage_valid_in;
   mssn_pkg::item_type stage_item_ff, stage_item_in;
   logic               accept;

   assign push      = stage_valid_ff && !qstat.full;
   assign busy      = stage_valid_ff && qstat.full;
   assign accept    = start && !busy;
   assign push_item = stage_item_ff;

   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !push);
      stage_item_in  = stage_item_ff;
      if (accept) begin
         stage_item_in.blank  = (req_cmd == mssn_pkg::CMD_CLEAR);
         stage_item_in.number = req_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

endmodule

>>> hw/rtl/mssn_queue.sv
module mssn_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mssn_pkg::item_type         push_item,
   input  logic                       pop,
   output mssn_pkg::item_type         pop_item,
   output mssn_pkg::queue_status_type qstat
);

   mssn_pkg::item_type                entry_ff [mssn_pkg::QUEUE_DEPTH];
   logic [mssn_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mssn_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mssn_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign qstat.full  = (count_ff == mssn_pkg::QCNT_W'(mssn_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_item    = entry_ff[rd_ptr_ff];

   function automatic logic [mssn_pkg::QPTR_W-1:0] next_ptr(
      input logic [mssn_pkg::QPTR_W-1:0] ptr);
      logic [mssn_pkg::QPTR_W-1:0] nxt;
      if (ptr == mssn_pkg::QPTR_W'(mssn_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/mssn_back.sv
module mssn_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mssn_pkg::queue_status_type    qstat,
   input  mssn_pkg::item_type            pop_item,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [mssn_pkg::SEG_W-1:0]    rsp_segments,
   output logic [mssn_pkg::DPLACE_W-1:0] rsp_digit_place,
   output logic                          rsp_last
);

   logic                            active_ff, active_in;
   logic [mssn_pkg::PLACE_W-1:0]    place_ff, place_in;
   logic [mssn_pkg::NUMBER_W-1:0]   rest_ff, rest_in;
   logic                            blank_ff, blank_in;

   logic                            rsp_valid_ff;
   logic [mssn_pkg::SEG_W-1:0]      rsp_seg_ff, rsp_seg_in;
   logic [mssn_pkg::DPLACE_W-1:0]   rsp_place_ff, rsp_place_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [mssn_pkg::PROD_W-1:0]     prod;
   logic [mssn_pkg::NUMBER_W-1:0]   quot;
   logic [mssn_pkg::NUMBER_W-1:0]   quot_x10;
   logic [3:0]                      digit;
   logic                            at_last;
   logic                            blank_now;

   always_comb begin
      prod      = mssn_pkg::PROD_W'(rest_ff) * mssn_pkg::PROD_W'(mssn_pkg::RECIP_TEN);
      quot      = mssn_pkg::NUMBER_W'(prod >> mssn_pkg::RECIP_SHIFT);
      quot_x10  = (quot << 3) + (quot << 1);
      digit     = 4'(rest_ff - quot_x10);
      at_last   = (place_ff == mssn_pkg::LAST_PLACE);
      blank_now = blank_ff || ((rest_ff == '0) && (place_ff != '0));
      pop       = !qstat.empty && (!active_ff || at_last);

      rsp_seg_in   = blank_now ? mssn_pkg::SEG_BLANK : mssn_pkg::seg_of(digit);
      rsp_place_in = mssn_pkg::DPLACE_W'(place_ff);
      rsp_last_in  = at_last;

      active_in = active_ff;
      place_in  = place_ff;
      rest_in   = rest_ff;
      blank_in  = blank_ff;
      if (pop) begin
         active_in = 1'b1;
         place_in  = '0;
         rest_in   = pop_item.number;
         blank_in  = pop_item.blank;
      end else if (active_ff) begin
         if (at_last) begin
            active_in = 1'b0;
         end else begin
            place_in = place_ff + 1'b1;
            rest_in  = quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= active_ff;
      end
      place_ff     <= place_in;
      rest_ff      <= rest_in;
      blank_ff     <= blank_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_place_ff <= rsp_place_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_segments    = rsp_seg_ff;
   assign rsp_digit_place = rsp_place_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> hw/rtl/multiplexed_seven_segment_number_unit.sv
// The first result strobes after the input stage, queue, sequencer and output
// register; the others follow on consecutive cycles, one per digit place.
// The back-end digit sequencer emits one place per cycle and pops the next
// request along with the last place; a 2-entry queue plus an input stage
// absorb bursts. Results cannot be stalled by the receiver.
// Reset (synchronous, active high) empties the input stage, queue and sequencer.
module multiplexed_seven_segment_number_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [mssn_pkg::NUMBER_W-1:0] req_number,
   output logic                          rsp_valid,
   output logic [mssn_pkg::SEG_W-1:0]    rsp_segments,
   output logic [mssn_pkg::DPLACE_W-1:0] rsp_digit_place,
   output logic                          rsp_last
);

   mssn_pkg::queue_status_type qstat;
   mssn_pkg::item_type         push_item;
   mssn_pkg::item_type         pop_item;
   logic                       push;
   logic                       pop;

   mssn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .req_number (req_number),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   mssn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   mssn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_segments    (rsp_segments),
      .rsp_digit_place (rsp_digit_place),
      .rsp_last        (rsp_last)
   );

endmodule

>>> dv/tb_multiplexed_seven_segment_number_unit.sv
module tb_multiplexed_seven_segment_number_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM   = 355;
   localparam int STALL_MAX  = 1000;
   localparam int DRAIN_WAIT = 12;

   // glyphs for 0..9, segment a in bit 0
   localparam logic [0:9][mssn_pkg::SEG_W-1:0] GLYPH = {
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   typedef struct packed {
      logic [mssn_pkg::SEG_W-1:0]    segments;
      logic [mssn_pkg::DPLACE_W-1:0] place;
      logic                          last;
   } digit_type;

   class digit_scoreboard;
      digit_type pending_digits[$];
      int        errors;

      function new();
         errors = 0;
      endfunction

      // expand one accepted request into its per-place patterns
      function void add_request(logic cmd, logic [mssn_pkg::NUMBER_W-1:0] number);
         int unsigned rest;
         digit_type d;
         rest = number;
         for (int p = 0; p < mssn_pkg::DIGITS; p++) begin
            if (cmd == mssn_pkg::CMD_CLEAR || (rest == 0 && p != 0)) begin
               d.segments = mssn_pkg::SEG_BLANK;
            end else begin
               d.segments = GLYPH[rest % 10];
               rest = rest / 10;
            end
            d.place = mssn_pkg::DPLACE_W'(p);
            d.last  = (p == mssn_pkg::DIGITS - 1);
            pending_digits.push_back(d);
         end
      endfunction

      function void check_digit(logic [mssn_pkg::SEG_W-1:0] segments,
                                logic [mssn_pkg::DPLACE_W-1:0] place,
                                logic last);
         digit_type want;
         if (pending_digits.size() == 0) begin
            $display("%0t: unexpected digit segments=%h place=%0d last=%0b",
                     $time, segments, place, last);
            errors++;
            return;
         end
         want = pending_digits.pop_front();
         if (segments !== want.segments) begin
            $display("%0t: segments mismatch: expected %h actual %h",
                     $time, want.segments, segments);
            errors++;
         end
         if (place !== want.place) begin
            $display("%0t: digit_place mismatch: expected %0d actual %0d",
                     $time, want.place, place);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0b actual %0b",
                     $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_cmd = mssn_pkg::CMD_SHOW;
   logic [mssn_pkg::NUMBER_W-1:0] req_number = '0;
   logic                          rsp_valid;
   logic [mssn_pkg::SEG_W-1:0]    rsp_segments;
   logic [mssn_pkg::DPLACE_W-1:0] rsp_digit_place;
   logic                          rsp_last;

   digit_scoreboard sb = new();
   int              stall_cycles = 0;

   multiplexed_seven_segment_number_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_segments    (rsp_segments),
      .rsp_digit_place (rsp_digit_place),
      .rsp_last        (rsp_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.add_request(req_cmd, req_number);
         end
         if (rsp_valid) begin
            sb.check_digit(rsp_segments, rsp_digit_place, rsp_last);
         end
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_MAX) begin
            $display("multiplexed_seven_segment_number_unit test failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // entered and left at a falling edge; start stays high into the next request
   task automatic send_request(logic cmd, logic [mssn_pkg::NUMBER_W-1:0] number);
      req_cmd    <= cmd;
      req_number <= number;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic pause(int cycles);
      start      <= 1'b0;
      req_cmd    <= 1'($urandom);
      req_number <= mssn_pkg::NUMBER_W'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [mssn_pkg::NUMBER_W-1:0] pick_number();
      case ($urandom_range(0, 5))
         0:       return mssn_pkg::NUMBER_W'($urandom_range(0, 9));
         1:       return mssn_pkg::NUMBER_W'($urandom_range(0, 99));
         2:       return mssn_pkg::NUMBER_W'($urandom_range(0, 999));
         3:       return mssn_pkg::NUMBER_W'($urandom_range(0, 9999));
         4:       return mssn_pkg::NUMBER_W'($urandom_range(10000, 16383));
         default: return mssn_pkg::NUMBER_W'($urandom_range(0, 16383));
      endcase
   endfunction

   initial begin
      logic [mssn_pkg::NUMBER_W-1:0] directed[$];
      int sent;
      int burst;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 100, 1000, 1005,
                   9999, 10000, 16383, 12345, 8888, 4096, 50};
      foreach (directed[i]) send_request(mssn_pkg::CMD_SHOW, directed[i]);
      send_request(mssn_pkg::CMD_CLEAR, '0);
      send_request(mssn_pkg::CMD_CLEAR, mssn_pkg::NUMBER_W'(16383));
      pause(3);
      send_request(mssn_pkg::CMD_SHOW, mssn_pkg::NUMBER_W'(1234));
      send_request(mssn_pkg::CMD_CLEAR, mssn_pkg::NUMBER_W'(777));

      sent = 0;
      while (sent < N_RANDOM) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
         repeat (burst) begin
            send_request(($urandom_range(0, 7) == 0) ? mssn_pkg::CMD_CLEAR
                                                      : mssn_pkg::CMD_SHOW,
                         pick_number());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 9));
      end
      start <= 1'b0;

      while (sb.pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0) begin
         $display("multiplexed_seven_segment_number_unit test passed");
      end else begin
         $display("multiplexed_seven_segment_number_unit test failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mssn_pkg.sv
hw/rtl/mssn_front.sv
hw/rtl/mssn_queue.sv
hw/rtl/mssn_back.sv
hw/rtl/multiplexed_seven_segment_number_unit.sv
dv/tb_multiplexed_seven_segment_number_unit.sv
